[rtl/core/sust_pkg.sv]
// Package for the sorted unique set table: payload structs, status and
// command codes, sequencer states and default sizing. No dependencies.
`default_nettype none

package sust_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int KEY_W            = 32;
   localparam int COUNT_OUT_W      = 5;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOTFOUND  = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      logic                    cmd;
      logic signed [KEY_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [COUNT_OUT_W-1:0]   entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHUP,
      S_WRKEY,
      S_SHDN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/core/sorted_unique_set_table.sv]
// Sorted unique set table: a bounded set of distinct signed keys kept in
// ascending order in a one-write, one-read memory. Depends on sust_pkg.
//
// One item at a time. An item runs a linear scan from position 0, one entry
// per cycle through the memory's registered read port, until the first entry
// not below the key; an insert then moves the larger entries up and an
// extract closes the gap, again one entry per cycle through the same port.
// From acceptance until ready again an item passes through acceptance, the
// scan, the decide state, the moves, the key write on an insert and the
// hand-over of the result, which waits while the previous result still sits
// in the output register; scan plus moves never exceed count + 1 entries.
// An empty table skips the scan.
// A finished result waits in the output register, and the next item is
// accepted while it waits. There is no clearing pass after reset:
// positions at or above the count may be read, but that data is never used.
`default_nettype none

module sorted_unique_set_table
   import sust_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    cmd_ff, cmd_in;
   logic                    hit_ff, hit_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [KEY_W-1:0] mem [CAPACITY];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic [CW-1:0]           rd_addr;
   logic                    wr_en;
   logic [CW-1:0]           wr_addr;
   logic signed [KEY_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[IW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      cmd_ff      <= cmd_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      cmd_in       = cmd_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = pos_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               key_in = req_data.value;
               cmd_in = req_data.cmd;
               pos_in = '0;
               hit_in = 1'b0;
               state_in = (count_ff == '0) ? S_DECIDE : S_SCAN;
            end
         end

         S_SCAN: begin
            // rd_data_ff holds the entry at pos_ff
            if (rd_data_ff < key_ff) begin
               pos_in  = pos_ff + CW'(1);
               rd_addr = pos_ff + CW'(1);
               if (pos_ff + CW'(1) == count_ff) begin
                  state_in = S_DECIDE;
               end
            end else begin
               hit_in   = (rd_data_ff == key_ff);
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (cmd_ff == CMD_INSERT) begin
               if (hit_ff) begin
                  status_in = ST_DUPLICATE;
                  state_in  = S_DONE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else if (pos_ff == count_ff) begin
                  state_in = S_WRKEY;
               end else begin
                  idx_in   = count_ff;
                  rd_addr  = count_ff - CW'(1);
                  state_in = S_SHUP;
               end
            end else begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else if (!hit_ff) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_DONE;
               end else if (pos_ff + CW'(1) == count_ff) begin
                  count_in  = count_ff - CW'(1);
                  status_in = ST_REMOVED;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = pos_ff;
                  rd_addr  = pos_ff + CW'(1);
                  state_in = S_SHDN;
               end
            end
         end

         S_SHUP: begin
            // move entry idx-1 up to idx, fetch idx-2 for the next cycle
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            idx_in  = idx_ff - CW'(1);
            rd_addr = idx_ff - CW'(2);
            if (idx_ff - CW'(1) == pos_ff) begin
               state_in = S_WRKEY;
            end
         end

         S_WRKEY: begin
            wr_en     = 1'b1;
            wr_addr   = pos_ff;
            wr_data   = key_ff;
            count_in  = count_ff + CW'(1);
            status_in = ST_INSERTED;
            state_in  = S_DONE;
         end

         S_SHDN: begin
            // move entry idx+1 down to idx, fetch idx+2 for the next cycle
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            idx_in  = idx_ff + CW'(1);
            rd_addr = idx_ff + CW'(2);
            if (idx_ff + CW'(2) == count_ff) begin
               count_in  = count_ff - CW'(1);
               status_in = ST_REMOVED;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.status      = status_ff;
               rsp_data_in.entry_count = COUNT_OUT_W'(count_ff);
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/sust_checker.sv]
// Port-level checker for the sorted unique set table, bound to the top level.
// Depends on sust_pkg.
`default_nettype none

module sust_checker
   import sust_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   localparam int CAP_OUT = CAPACITY;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // ready is low right after an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted item");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_INSERTED || rsp_data.status == ST_DUPLICATE ||
                     rsp_data.status == ST_REMOVED || rsp_data.status == ST_NOTFOUND ||
                     rsp_data.status == ST_EMPTY || rsp_data.status == ST_FULL))
      else $error("undefined status code");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.entry_count == '0)
      else $error("empty status with nonzero count");

   a_removed_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_REMOVED && CAP_OUT < 32
      |-> rsp_data.entry_count < COUNT_OUT_W'(CAP_OUT))
      else $error("count after a removal not below capacity");

endmodule

bind sorted_unique_set_table sust_checker #(.CAPACITY(CAPACITY)) u_sust_checker (.*);

`default_nettype wire

[tb/sv/sorted_unique_set_table_test.sv]
// Testbench for sorted_unique_set_table: directed and random insert/extract
// items checked against a built-in model of the sorted set.
// Depends on sust_pkg and the sorted_unique_set_table RTL.
`timescale 1ns / 100ps

module sorted_unique_set_table_test;
   import sust_pkg::*;

   localparam int SET_CAPACITY  = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = 2 * SET_CAPACITY + 8;
   localparam int POOL_SIZE     = 24;
   localparam int PRINT_LIMIT   = 100;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_LONG} ready_mode_type;
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;

   typedef struct {
      req_type item;
      bit      wait_drained;
   } queued_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   queued_op_type pending_ops[$];
   rsp_type       set_results[$];

   logic signed [KEY_W-1:0] model_keys [SET_CAPACITY];
   int                      model_count = 0;

   int mismatch_count = 0;
   int results_seen   = 0;
   int total_ops      = 0;
   int accepted_ops   = 0;
   int cycle_count    = 0;

   int             burst_left = 20;
   int             gap_left   = 0;
   queued_op_type  next_op;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             hold_left  = 0;
   rsp_type        want;

   logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
   logic signed [KEY_W-1:0] fill_keys [14] = '{
      -32'sd1, 32'sd0, 32'sd1, 32'sd2, -32'sd2, 32'sd100, -32'sd100,
      32'sh4000_0000, -32'sh4000_0000, 32'sh0000_0FFF, 32'sh7FFF_FFFE,
      32'sh8000_0001, 32'sh1234_5678, 32'shEDCB_A988};

   sorted_unique_set_table #(.CAPACITY(SET_CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one insert or extract to the model set and return its result.
   function automatic rsp_type apply_set_op(req_type op);
      logic signed [KEY_W-1:0] key;
      rsp_type                 res;
      int                      pos;
      int                      i;
      key = op.value;
      pos = 0;
      while (pos < model_count && model_keys[pos] < key) pos++;
      if (op.cmd == CMD_INSERT) begin
         if (pos < model_count && model_keys[pos] == key) begin
            res.status = ST_DUPLICATE;
         end else if (model_count >= SET_CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            for (i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
            model_keys[pos] = key;
            model_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         if (model_count == 0) begin
            res.status = ST_EMPTY;
         end else if (pos >= model_count || model_keys[pos] != key) begin
            res.status = ST_NOTFOUND;
         end else begin
            for (i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
            model_count--;
            res.status = ST_REMOVED;
         end
      end
      res.entry_count = COUNT_OUT_W'(model_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  results_seen, what, got, exp_val);
   endtask

   task automatic add_op(input logic cmd, input logic signed [KEY_W-1:0] value,
                         input bit wait_drained);
      queued_op_type op;
      op.item.cmd   = cmd;
      op.item.value = value;
      op.wait_drained = wait_drained;
      pending_ops.push_back(op);
   endtask

   task automatic refresh_pool();
      int k;
      for (k = 0; k < POOL_SIZE; k++) begin
         case ($urandom_range(0, 3))
            0: key_pool[k] = $urandom;
            1: key_pool[k] = $signed($urandom_range(0, 40)) - 20;
            2: key_pool[k] = ($urandom_range(0, 1) != 0) ? KEY_MAX - $urandom_range(0, 3)
                                                        : KEY_MIN + $urandom_range(0, 3);
            default: key_pool[k] = $urandom_range(0, 255);
         endcase
      end
   endtask

   function automatic int pick_gap();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return $urandom_range(1, 5);
         default: return $urandom_range(6, 45);
      endcase
   endfunction

   // Sender: bursts of items with random gaps, optional hold until drained.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            set_results.push_back(apply_set_op(req_data));
            accepted_ops++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               gap_left   = pick_gap();
               burst_left = $urandom_range(1, 40);
            end
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_ops[0].wait_drained && set_results.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               next_op = pending_ops.pop_front();
               req_data  <= next_op.item;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Receiver: switch between always ready, coin flips and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0: ready_mode = READY_ALWAYS;
               1: ready_mode = READY_COIN;
               default: ready_mode = READY_LONG;
            endcase
            mode_left = $urandom_range(100, 400);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
               end else begin
                  hold_left = rsp_ready ? $urandom_range(1, 60) : $urandom_range(0, 8);
                  rsp_ready <= !rsp_ready;
               end
            end
         endcase
      end
   end

   // Monitor: compare each accepted result with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (set_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_data.status, -1);
         end else begin
            want = set_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** sorted_unique_set_table: FAILED **");
         $finish;
      end
   end

   initial begin
      int         n;
      int         k;
      int         insert_pct;
      op_mix_type mix;
      logic       cmd;
      logic signed [KEY_W-1:0] value;

      // Empty table, extremes, duplicate, missing key, first and last entry.
      add_op(CMD_EXTRACT, 32'sd0, 1'b0);
      add_op(CMD_INSERT, KEY_MAX, 1'b0);
      add_op(CMD_INSERT, KEY_MIN, 1'b0);
      add_op(CMD_INSERT, KEY_MAX, 1'b0);
      add_op(CMD_EXTRACT, 32'sd7, 1'b0);
      add_op(CMD_EXTRACT, KEY_MIN, 1'b0);
      add_op(CMD_EXTRACT, KEY_MAX, 1'b0);
      // Fill to capacity, then a new key and a held key on the full table.
      add_op(CMD_INSERT, KEY_MAX, 1'b0);
      add_op(CMD_INSERT, KEY_MIN, 1'b0);
      for (k = 0; k < 14; k++) add_op(CMD_INSERT, fill_keys[k], 1'b0);
      add_op(CMD_INSERT, 32'sd55, 1'b0);
      add_op(CMD_INSERT, KEY_MIN, 1'b0);
      add_op(CMD_EXTRACT, KEY_MIN, 1'b0);

      refresh_pool();
      insert_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: mix = MIX_FILL;
               1: mix = MIX_DRAIN;
               default: mix = MIX_EVEN;
            endcase
            insert_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
            refresh_pool();
         end
         cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
         case ($urandom_range(0, 9))
            0: value = $urandom;
            1: value = ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
            default: value = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         endcase
         add_op(cmd, value, (n % 300 == 0));
      end
      total_ops = pending_ops.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_ops != total_ops) @(posedge clock);
      while (set_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** sorted_unique_set_table: PASSED **");
      end else begin
         $display("** sorted_unique_set_table: FAILED **");
      end
      $finish;
   end

endmodule
